@@ sv/lsp_pkg.sv @@
// Shared types and constants for the LIFO stack with peek.
// Used by lsp_ctrl, lsp_datapath and lifo_stack_with_peek; no dependencies.
`default_nettype none

package lsp_pkg;

    // operation kinds
    localparam logic [2:0] KIND_PUSH     = 3'd0;
    localparam logic [2:0] KIND_POP      = 3'd1;
    localparam logic [2:0] KIND_PEEK_TOP = 3'd2;
    localparam logic [2:0] KIND_PEEK_POS = 3'd3;
    localparam logic [2:0] KIND_BOTTOM   = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_BADPOS   = 2'd3;

    localparam logic [4:0]         CAP_RESET = 5'd10;
    localparam logic signed [31:0] ERR_WORD  = -32'sd1;

    typedef struct packed {
        logic [2:0]         kind;
        logic signed [31:0] push_value;
        logic [4:0]         position;
    } t_in_word;

    typedef struct packed {
        logic signed [31:0] data;
        logic [1:0]         status;
        logic [4:0]         fill_level;
    } t_out_word;

    // controller to datapath commands
    typedef struct packed {
        logic capture;  // latch the accepted word
        logic eval;     // decide, update count, access the store
        logic load;     // fill the output register
    } t_dp_cmd;

endpackage

`default_nettype wire

@@ sv/lsp_ctrl.sv @@
// Sequencer for the LIFO stack: capture, evaluate, load result.
// Depends on lsp_pkg for the command struct.
`default_nettype none

module lsp_ctrl (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_stall,
    output logic             o_out_valid,
    input  wire              i_out_stall,
    output lsp_pkg::t_dp_cmd o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EVAL = 2'd1;
    localparam logic [1:0] S_LOAD = 2'd2;

    logic [1:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       out_free;

    // output register can take a word when empty or being drained now
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    // advance the sequence
    always_comb begin
        n_state       = r_state;
        o_cmd.capture = 1'b0;
        o_cmd.eval    = 1'b0;
        o_cmd.load    = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EVAL;
                end
            end
            S_EVAL: begin
                o_cmd.eval = 1'b1;
                n_state    = S_LOAD;
            end
            S_LOAD: begin
                if (out_free) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // hold the output word until it is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

@@ sv/lsp_datapath.sv @@
// Datapath of the LIFO stack: entry store, fill count, capacity and result register.
// Depends on lsp_pkg for word types, kinds, status codes and commands.
`default_nettype none

module lsp_datapath #(
    parameter int DEPTH = 16
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  lsp_pkg::t_dp_cmd  i_cmd,
    input  lsp_pkg::t_in_word i_in_word,
    input  wire               i_cfg_we,
    input  wire [4:0]         i_cfg_data,
    output lsp_pkg::t_out_word o_out_word
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = $clog2(DEPTH);
    localparam int XW = (CW > 5) ? CW : 5;
    localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

    logic signed [31:0] mem [DEPTH];

    logic [4:0]         r_capacity;
    logic [CW-1:0]      r_count, n_count;
    logic [2:0]         r_kind;
    logic signed [31:0] r_push_value;
    logic [4:0]         r_position;
    logic [1:0]         r_status, n_status;
    logic               r_use_rd, n_use_rd;
    logic signed [31:0] r_rdata;
    lsp_pkg::t_out_word r_out;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [XW-1:0] cnt_x, cap_x, pos_x;
    logic          full;

    assign cnt_x = XW'(r_count);
    assign cap_x = XW'(r_capacity);
    assign pos_x = XW'(r_position);
    assign full  = (cnt_x >= cap_x) || (cnt_x >= DEPTH_X);

    // decide the operation from the held word and the fill count
    always_comb begin
        n_count  = r_count;
        n_status = lsp_pkg::ST_OK;
        n_use_rd = 1'b0;
        wr_en    = 1'b0;
        rd_en    = 1'b0;
        wr_addr  = AW'(r_count);
        rd_addr  = AW'(cnt_x - XW'(1));
        case (r_kind)
            lsp_pkg::KIND_PUSH: begin
                if (full) begin
                    n_status = lsp_pkg::ST_OVERFLOW;
                end else begin
                    wr_en   = i_cmd.eval;
                    n_count = CW'(r_count + 1'b1);
                end
            end
            lsp_pkg::KIND_POP: begin
                if (r_count == '0) begin
                    n_status = lsp_pkg::ST_EMPTY;
                end else begin
                    rd_en    = i_cmd.eval;
                    n_use_rd = 1'b1;
                    n_count  = CW'(r_count - 1'b1);
                end
            end
            lsp_pkg::KIND_PEEK_TOP: begin
                if (r_count == '0) begin
                    n_status = lsp_pkg::ST_EMPTY;
                end else begin
                    rd_en    = i_cmd.eval;
                    n_use_rd = 1'b1;
                end
            end
            lsp_pkg::KIND_PEEK_POS: begin
                if (r_position == 5'd0 || pos_x > cnt_x) begin
                    n_status = lsp_pkg::ST_BADPOS;
                end else begin
                    rd_en    = i_cmd.eval;
                    n_use_rd = 1'b1;
                    rd_addr  = AW'(cnt_x - pos_x);
                end
            end
            lsp_pkg::KIND_BOTTOM: begin
                if (r_count == '0) begin
                    n_status = lsp_pkg::ST_EMPTY;
                end else begin
                    rd_en    = i_cmd.eval;
                    n_use_rd = 1'b1;
                    rd_addr  = '0;
                end
            end
            default: begin
                n_status = lsp_pkg::ST_BADPOS;
            end
        endcase
    end

    // entry store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= r_push_value;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // control state: capacity and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= lsp_pkg::CAP_RESET;
            r_count    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_capacity <= i_cfg_data;
            end
            if (i_cmd.eval) begin
                r_count <= n_count;
            end
        end
    end

    // hold the accepted word and the decision
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind       <= i_in_word.kind;
            r_push_value <= i_in_word.push_value;
            r_position   <= i_in_word.position;
        end
        if (i_cmd.eval) begin
            r_status <= n_status;
            r_use_rd <= n_use_rd;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out.status     <= r_status;
            r_out.fill_level <= 5'(r_count);
            if (r_status != lsp_pkg::ST_OK) begin
                r_out.data <= lsp_pkg::ERR_WORD;
            end else if (r_use_rd) begin
                r_out.data <= r_rdata;
            end else begin
                r_out.data <= '0;
            end
        end
    end

    assign o_out_word = r_out;

endmodule

`default_nettype wire

@@ sv/lifo_stack_with_peek.sv @@
// Top level of the LIFO stack with peek: sequencer plus datapath.
// Depends on lsp_pkg, lsp_ctrl and lsp_datapath.
//
//   channel   direction  handshake                  payload
//   in        input      i_in_valid / o_in_stall    i_in_word  (t_in_word)
//   out       output     o_out_valid / i_out_stall  o_out_word (t_out_word)
//   cfg       input      i_cfg_we                   i_cfg_data (capacity)
//
// Each word passes through capture, evaluate with a registered store
// read, then load of the output register; a new word is taken only after
// the last one is loaded. The output register holds a result under
// stall; the load step waits until it is free. Synchronous reset empties the
// stack and sets capacity to 10; store contents are left as they are.
`default_nettype none

module lifo_stack_with_peek #(
    parameter int DEPTH = 16
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  lsp_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output lsp_pkg::t_out_word  o_out_word,
    input  wire                 i_cfg_we,
    input  wire [4:0]           i_cfg_data
);

    lsp_pkg::t_dp_cmd cmd;

    lsp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    lsp_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_word  (i_in_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_out_word (o_out_word)
    );

endmodule

`default_nettype wire
